// ----- hdl/hdlcbs_pkg.sv -----
// Shared types and constants for the HDLC bit-stuffing framer.
package hdlcbs_pkg;

	localparam logic [7:0] FLAG_RESET  = 8'h7E;
	localparam logic [2:0] STUFF_LIMIT = 3'd5;
	localparam int         QUEUE_DEPTH = 4;

	// One classified input bit, as handed from front to back.
	typedef struct packed {
		logic data_bit;
		logic first;
		logic last;
		logic stuff;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_HEAD,
		PH_OPEN,
		PH_DATA,
		PH_STUFF,
		PH_CLOSE
	} phase_t;

endpackage

// ----- hdl/hdlcbs_front.sv -----
// Front end: accepts input beats, tracks the ones run and decides stuffing.
module hdlcbs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               data_bit,
	input  logic               frame_first,
	input  logic               frame_last,
	input  logic               q_full,
	output logic               push,
	output hdlcbs_pkg::cmd_t   cmd,
	output logic [2:0]         ones_run
);

	logic [2:0] ones_run_q;
	logic [2:0] run_base;
	logic [2:0] run_inc;
	logic       stuff;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// frame start clears the run before this bit is counted
	assign run_base = frame_first ? 3'd0 : ones_run_q;
	assign run_inc  = run_base + 3'd1;
	assign stuff    = data_bit && (run_inc == hdlcbs_pkg::STUFF_LIMIT);

	always_comb begin
		cmd.data_bit = data_bit;
		cmd.first    = frame_first;
		cmd.last     = frame_last;
		cmd.stuff    = stuff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ones_run_q <= 3'd0;
		end else if (push) begin
			if (!data_bit || stuff) begin
				ones_run_q <= 3'd0;
			end else begin
				ones_run_q <= run_inc;
			end
		end
	end

	assign ones_run = ones_run_q;

endmodule

// ----- hdl/hdlcbs_queue.sv -----
// Short command queue between front and back.
module hdlcbs_queue #(
	parameter int DEPTH = hdlcbs_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hdlcbs_pkg::cmd_t push_cmd,
	input  logic             pop,
	output hdlcbs_pkg::cmd_t head,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hdlcbs_pkg::cmd_t slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_pop;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign head   = slot_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/hdlcbs_back.sv -----
// Back end: expands each command into flag, payload and stuffed line beats.
module hdlcbs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       flag_pattern,
	input  hdlcbs_pkg::cmd_t head,
	input  logic             q_empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             line_bit,
	output logic             is_flag,
	output logic             is_stuffed,
	output logic             run_end
);

	hdlcbs_pkg::phase_t phase_q;
	hdlcbs_pkg::phase_t phase_cur;
	hdlcbs_pkg::phase_t phase_d;
	logic [2:0]         idx_q;
	logic [2:0]         idx_d;
	logic               advance;
	logic               emit;
	logic               beat_bit;
	logic               beat_flag;
	logic               beat_stuffed;
	logic               beat_done;
	logic               out_valid_q;
	logic               line_bit_q;
	logic               is_flag_q;
	logic               is_stuffed_q;
	logic               run_end_q;

	assign advance = !out_valid_q || !out_stall;
	assign emit    = advance && !q_empty;
	assign pop     = emit && beat_done;

	always_comb begin
		if (phase_q == hdlcbs_pkg::PH_HEAD) begin
			phase_cur = head.first ? hdlcbs_pkg::PH_OPEN : hdlcbs_pkg::PH_DATA;
		end else begin
			phase_cur = phase_q;
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		if (emit) begin
			case (phase_cur)
				hdlcbs_pkg::PH_OPEN: begin
					idx_d   = idx_q + 3'd1;
					phase_d = (idx_q == 3'd7) ? hdlcbs_pkg::PH_DATA : hdlcbs_pkg::PH_OPEN;
				end
				hdlcbs_pkg::PH_DATA: begin
					if (head.stuff) begin
						phase_d = hdlcbs_pkg::PH_STUFF;
					end else if (head.last) begin
						phase_d = hdlcbs_pkg::PH_CLOSE;
					end else begin
						phase_d = hdlcbs_pkg::PH_HEAD;
					end
				end
				hdlcbs_pkg::PH_STUFF: begin
					phase_d = head.last ? hdlcbs_pkg::PH_CLOSE : hdlcbs_pkg::PH_HEAD;
				end
				hdlcbs_pkg::PH_CLOSE: begin
					idx_d   = idx_q + 3'd1;
					phase_d = (idx_q == 3'd7) ? hdlcbs_pkg::PH_HEAD : hdlcbs_pkg::PH_CLOSE;
				end
				default: begin
					phase_d = hdlcbs_pkg::PH_HEAD;
					idx_d   = 3'd0;
				end
			endcase
		end
	end

	// beat contents; flag bits go MSB first, so bit index is ~idx
	always_comb begin
		beat_bit     = 1'b0;
		beat_flag    = 1'b0;
		beat_stuffed = 1'b0;
		beat_done    = 1'b0;
		case (phase_cur)
			hdlcbs_pkg::PH_OPEN: begin
				beat_bit  = flag_pattern[~idx_q];
				beat_flag = 1'b1;
			end
			hdlcbs_pkg::PH_DATA: begin
				beat_bit  = head.data_bit;
				beat_done = !head.stuff && !head.last;
			end
			hdlcbs_pkg::PH_STUFF: begin
				beat_stuffed = 1'b1;
				beat_done    = !head.last;
			end
			hdlcbs_pkg::PH_CLOSE: begin
				beat_bit  = flag_pattern[~idx_q];
				beat_flag = 1'b1;
				beat_done = (idx_q == 3'd7);
			end
			default: begin
				beat_done = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hdlcbs_pkg::PH_HEAD;
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			line_bit_q   <= beat_bit;
			is_flag_q    <= beat_flag;
			is_stuffed_q <= beat_stuffed;
			run_end_q    <= beat_done;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_bit   = line_bit_q;
	assign is_flag    = is_flag_q;
	assign is_stuffed = is_stuffed_q;
	assign run_end    = run_end_q;

endmodule

// ----- hdl/hdlc_bit_stuff_framer_unit.sv -----
// HDLC framer top: flag register, front end, command queue and back end.
// An accepted bit is written into a queue slot; its first line beat is then registered by the back end.
// Throughput: one input bit per cycle while the queue is not full; an item gives its payload beat,
// plus opening flag, stuffed zero and closing flag beats as needed, at one beat/cycle unless out_stall holds.
// The queue lets the front keep taking bits while the back end sends flags.
// Reset: flag pattern 0x7E, ones run cleared, queue empty, no output beat pending.
module hdlc_bit_stuff_framer_unit #(
	parameter int QUEUE_DEPTH = hdlcbs_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       data_bit,
	input  logic       frame_first,
	input  logic       frame_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       line_bit,
	output logic       is_flag,
	output logic       is_stuffed,
	output logic       run_end
);

	logic [7:0]       flag_pattern_q;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	logic [2:0]       ones_run;
	hdlcbs_pkg::cmd_t push_cmd;
	hdlcbs_pkg::cmd_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_pattern_q <= hdlcbs_pkg::FLAG_RESET;
		end else if (cfg_wr_en) begin
			flag_pattern_q <= cfg_wr_data;
		end
	end

	hdlcbs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_bit    (data_bit),
		.frame_first (frame_first),
		.frame_last  (frame_last),
		.q_full      (q_full),
		.push        (push),
		.cmd         (push_cmd),
		.ones_run    (ones_run)
	);

	hdlcbs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	hdlcbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.flag_pattern (flag_pattern_q),
		.head         (head),
		.q_empty      (q_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_bit     (line_bit),
		.is_flag      (is_flag),
		.is_stuffed   (is_stuffed),
		.run_end      (run_end)
	);

	// run of ones never reaches the stuffing limit once stored
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ones_run < hdlcbs_pkg::STUFF_LIMIT)
		else $error("ones run reached stuffing limit");

	// a stuffed beat is a plain zero
	a_stuff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_stuffed) |-> (!line_bit && !is_flag))
		else $error("stuffed beat malformed");

	// pending work with a free output register yields a beat next cycle
	a_back_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && (!out_valid || !out_stall)) |=> out_valid)
		else $error("back end did not emit");

endmodule

// ----- dv/hdlc_framer_checker.sv -----
// Line-side scoreboard for the HDLC framer: predicts every line beat and checks it in order.
module hdlc_framer_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       data_bit,
	input  logic       frame_first,
	input  logic       frame_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       line_bit,
	input  logic       is_flag,
	input  logic       is_stuffed,
	input  logic       run_end,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic line_bit;
		logic is_flag;
		logic is_stuffed;
		logic run_end;
	} line_beat_t;

	line_beat_t line_expect[$];
	logic [7:0] flag_reg;
	logic [2:0] ones_seen;

	initial fail_count = 0;

	function automatic void push_beat(input logic b, input logic flag, input logic stuffed);
		line_beat_t beat;
		beat = '{line_bit: b, is_flag: flag, is_stuffed: stuffed, run_end: 1'b0};
		line_expect.push_back(beat);
	endfunction

	function automatic void push_flag();
		for (int i = 7; i >= 0; i--)
			push_beat(flag_reg[i], 1'b1, 1'b0);
	endfunction

	// Expected line beats for one accepted payload bit.
	function automatic void frame_payload_bit(input logic d, input logic f, input logic l);
		line_beat_t tail;
		if (f) begin
			push_flag();
			ones_seen = '0;
		end
		push_beat(d, 1'b0, 1'b0);
		if (d) begin
			ones_seen = ones_seen + 3'd1;
			if (ones_seen >= hdlcbs_pkg::STUFF_LIMIT) begin
				push_beat(1'b0, 1'b0, 1'b1);
				ones_seen = '0;
			end
		end else begin
			ones_seen = '0;
		end
		if (l)
			push_flag();
		// last beat of this bit carries the run marker
		tail = line_expect.pop_back();
		tail.run_end = 1'b1;
		line_expect.push_back(tail);
	endfunction

	function automatic void check_field(input string name, input logic want, input logic got);
		if (want !== got) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		line_beat_t want;
		if (!arst_n) begin
			line_expect.delete();
			flag_reg = hdlcbs_pkg::FLAG_RESET;
			ones_seen = '0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (line_expect.size() == 0) begin
					$error("line beat with no expected beat pending");
					fail_count++;
				end else begin
					want = line_expect.pop_front();
					check_field("line_bit", want.line_bit, line_bit);
					check_field("is_flag", want.is_flag, is_flag);
					check_field("is_stuffed", want.is_stuffed, is_stuffed);
					check_field("run_end", want.run_end, run_end);
				end
			end
			if (in_valid && !in_stall)
				frame_payload_bit(data_bit, frame_first, frame_last);
			if (cfg_wr_en)
				flag_reg = cfg_wr_data;
			pending <= line_expect.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
// Top of the HDLC framer bench: clock, reset, bit stimulus, line stalls and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       data_bit = 1'b0;
	logic       frame_first = 1'b0;
	logic       frame_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       line_bit;
	logic       is_flag;
	logic       is_stuffed;
	logic       run_end;

	int fail_count;
	int pending;
	int cycle_count = 0;
	bit quiet = 1'b0;
	bit long_hold = 1'b0;

	hdlc_bit_stuff_framer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_bit    (data_bit),
		.frame_first (frame_first),
		.frame_last  (frame_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.line_bit    (line_bit),
		.is_flag     (is_flag),
		.is_stuffed  (is_stuffed),
		.run_end     (run_end)
	);

	hdlc_framer_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_bit    (data_bit),
		.frame_first (frame_first),
		.frame_last  (frame_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.line_bit    (line_bit),
		.is_flag     (is_flag),
		.is_stuffed  (is_stuffed),
		.run_end     (run_end),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Line side: random stall bursts, one long hold-off on request, none when quiet.
	initial begin : line_stall_gen
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one payload bit and hold it until the beat is taken.
	task automatic send_bit(input logic d, input logic f, input logic l);
		in_valid <= 1'b1;
		data_bit <= d;
		frame_first <= f;
		frame_last <= l;
		do @(posedge clk); while (in_stall);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Mostly well-formed frames; some bits between frames and some frames missing a start or an end.
	task automatic random_traffic(input int n);
		int sent;
		int kind;
		int len;
		int pct;
		logic b;
		logic f;
		logic l;
		sent = 0;
		while (sent < n) begin
			kind = $urandom_range(0, 9);
			len = $urandom_range(1, 12);
			pct = $urandom_range(40, 95);
			for (int i = 0; i < len; i++) begin
				b = ($urandom_range(0, 99) < pct);
				f = (kind <= 7 || (kind == 9 && len % 2 == 1)) && i == 0;
				l = (kind <= 7 || (kind == 9 && len % 2 == 0)) && i == len - 1;
				send_bit(b, f, l);
				sent++;
			end
		end
	endtask

	// stop offering, then wait until every predicted line beat has been taken
	task automatic wait_drained(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (extra) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [7:0] flag_plan [5];
		flag_plan[0] = 8'h00;
		flag_plan[1] = 8'hFF;
		flag_plan[2] = 8'($urandom_range(0, 255));
		flag_plan[3] = 8'h7E;
		flag_plan[4] = 8'($urandom_range(0, 255));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-bit frames
		send_bit(1'b0, 1'b1, 1'b1);
		send_bit(1'b1, 1'b1, 1'b1);
		// two stuffing runs in one frame, then a zero and a closing one
		send_bit(1'b1, 1'b1, 1'b0);
		repeat (9) send_bit(1'b1, 1'b0, 1'b0);
		send_bit(1'b0, 1'b0, 1'b0);
		send_bit(1'b1, 1'b0, 1'b1);
		// between frames: the count carries over and still stuffs
		repeat (4) send_bit(1'b1, 1'b0, 1'b0);
		// opening bit clears a nonzero count; stuffed zero right before closing flag
		send_bit(1'b1, 1'b0, 1'b0);
		send_bit(1'b1, 1'b1, 1'b0);
		repeat (3) send_bit(1'b1, 1'b0, 1'b0);
		send_bit(1'b1, 1'b0, 1'b1);

		for (int p = 0; p < 5; p++) begin
			wait_drained(4);
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= flag_plan[p];
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			if (p == 1)
				long_hold = 1'b1;
			if (p == 4)
				quiet = 1'b1;
			random_traffic(20);
		end

		wait_drained(20);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- hdlc_bit_stuff_framer_unit.f -----
hdl/hdlcbs_pkg.sv
hdl/hdlcbs_front.sv
hdl/hdlcbs_queue.sv
hdl/hdlcbs_back.sv
hdl/hdlc_bit_stuff_framer_unit.sv
dv/hdlc_framer_checker.sv
dv/testbench.sv
